### rtl/core/mwo_pkg.sv
// ----------------------------------------------------------------------------
// mwo_pkg: shared types and constants for the mecanum wheel odometry block
// Command codes, fixed field widths, pipeline control groups.
// ----------------------------------------------------------------------------
package mwo_pkg;

  localparam int NUM_WHEELS   = 4;
  localparam int CMD_BITS     = 2;
  localparam int SCALE_BITS   = 32;
  localparam int OUT_BITS     = 48;
  localparam int ROUND_SHIFT  = 18;
  localparam int HI_SHIFT     = SCALE_BITS - ROUND_SHIFT;
  localparam int PIPE_STAGES  = 8;

  localparam logic [CMD_BITS-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_REREF  = 2'd2;

  localparam logic [SCALE_BITS-1:0] MM_PER_COUNT_RESET = 32'd6501707;

  localparam logic [OUT_BITS-1:0] OUT_POS_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] OUT_NEG_MAG = {1'b1, {(OUT_BITS-1){1'b0}}};

  // load enables of the merge and accumulate stages
  typedef struct packed {
    logic merge_ld;
    logic acc_ld;
  } acc_ctl_t;

  // load enables of the scaling pipeline
  typedef struct packed {
    logic abs_ld;
    logic mul_lo_ld;
    logic mul_hi_ld;
    logic sat_ld;
    logic out_ld;
  } scale_ctl_t;

endpackage

### rtl/core/mwo_wheel_lane.sv
// ----------------------------------------------------------------------------
// mwo_wheel_lane: one wheel's angle tracker
// Holds the last angle and registers the unwrapped angle change of a beat.
// ----------------------------------------------------------------------------
module mwo_wheel_lane #(
  parameter int ANGLE_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ld,
  input  logic                         is_update,
  input  logic                         first_pass,
  input  logic                         wheel_valid,
  input  logic [ANGLE_BITS-1:0]        wheel_count,
  output logic signed [ANGLE_BITS:0]   delta_r
);

  localparam logic signed [ANGLE_BITS:0] HALF     = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 1);
  localparam logic signed [ANGLE_BITS:0] NEG_HALF = -HALF;
  // adding or subtracting a full turn is the same flip of the sign bit here
  localparam logic [ANGLE_BITS:0]        FULL     = {1'b1, {ANGLE_BITS{1'b0}}};

  logic [ANGLE_BITS-1:0]      last_r;
  logic signed [ANGLE_BITS:0] diff;
  logic signed [ANGLE_BITS:0] wrapped;
  logic                       use_wheel;

  always_comb begin
    diff      = $signed({1'b0, wheel_count}) - $signed({1'b0, last_r});
    wrapped   = ((diff > HALF) || (diff < NEG_HALF)) ? $signed(diff ^ FULL) : diff;
    use_wheel = is_update && wheel_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (ld && use_wheel) begin
      last_r <= wheel_count;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      delta_r <= (use_wheel && !first_pass) ? wrapped : '0;
    end
  end

endmodule

### rtl/core/mwo_body_acc.sv
// ----------------------------------------------------------------------------
// mwo_body_acc: mecanum merge and body accumulators
// Combines the four wheel deltas into body sums and accumulates them, saturated.
// ----------------------------------------------------------------------------
module mwo_body_acc #(
  parameter int ANGLE_BITS = 13,
  parameter int SUM_BITS   = 40
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  mwo_pkg::acc_ctl_t                            ctl,
  input  logic [mwo_pkg::CMD_BITS-1:0]                 cmd_in,
  input  logic [mwo_pkg::NUM_WHEELS-1:0][ANGLE_BITS:0] deltas,
  output logic signed [SUM_BITS-1:0]                   sum_x_r,
  output logic signed [SUM_BITS-1:0]                   sum_y_r
);

  localparam int DW = ANGLE_BITS + 3;
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  logic signed [DW-1:0]            d0, d1, d2, d3;
  logic signed [DW-1:0]            dx_nxt, dy_nxt;
  logic signed [DW-1:0]            dx_r, dy_r;
  logic [mwo_pkg::CMD_BITS-1:0]    cmd_r;
  logic signed [SUM_BITS:0]        sx_wide, sy_wide;
  logic signed [SUM_BITS-1:0]      sum_x_nxt, sum_y_nxt;

  function automatic logic signed [SUM_BITS-1:0] clamp(input logic signed [SUM_BITS:0] s);
    logic signed [SUM_BITS-1:0] res;
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      res = s[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      res = s[SUM_BITS-1:0];
    end
    return res;
  endfunction

  always_comb begin
    d0     = DW'($signed(deltas[0]));
    d1     = DW'($signed(deltas[1]));
    d2     = DW'($signed(deltas[2]));
    d3     = DW'($signed(deltas[3]));
    dx_nxt = d0 + d1 - d2 - d3;
    dy_nxt = d1 - d0 - d2 + d3;
  end

  always_ff @(posedge clk) begin
    if (ctl.merge_ld) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      cmd_r <= cmd_in;
    end
  end

  always_comb begin
    sx_wide = (SUM_BITS+1)'(sum_x_r) + (SUM_BITS+1)'(dx_r);
    sy_wide = (SUM_BITS+1)'(sum_y_r) + (SUM_BITS+1)'(dy_r);
    case (cmd_r)
      mwo_pkg::CMD_UPDATE: begin
        sum_x_nxt = clamp(sx_wide);
        sum_y_nxt = clamp(sy_wide);
      end
      mwo_pkg::CMD_CLEAR: begin
        sum_x_nxt = '0;
        sum_y_nxt = '0;
      end
      default: begin
        sum_x_nxt = sum_x_r;
        sum_y_nxt = sum_y_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else if (ctl.acc_ld) begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
    end
  end

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc_ld && (cmd_r == mwo_pkg::CMD_CLEAR) |=> (sum_x_r == '0) && (sum_y_r == '0))
    else $error("accumulators not zero after clear");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.acc_ld |=> $stable(sum_x_r) && $stable(sum_y_r))
    else $error("accumulator moved without a beat");

  a_other_cmd_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc_ld && (cmd_r != mwo_pkg::CMD_UPDATE) && (cmd_r != mwo_pkg::CMD_CLEAR)
    |=> $stable(sum_x_r) && $stable(sum_y_r))
    else $error("accumulator moved on a command that leaves it alone");

endmodule

### rtl/core/mwo_scale.sv
// ----------------------------------------------------------------------------
// mwo_scale: accumulator to millimetre Q32.16 scaler
// Sign-magnitude multiply by the Q0.32 scale in two partial products, round, saturate.
// ----------------------------------------------------------------------------
module mwo_scale #(
  parameter int SUM_BITS = 40
) (
  input  logic                                clk,
  input  mwo_pkg::scale_ctl_t                 ctl,
  input  logic [mwo_pkg::SCALE_BITS-1:0]      mm_per_count,
  input  logic signed [SUM_BITS-1:0]          acc,
  output logic [mwo_pkg::OUT_BITS-1:0]        out_r
);

  localparam int SB      = mwo_pkg::SCALE_BITS;
  localparam int HI_BITS = (SUM_BITS > SB) ? (SUM_BITS - SB) : 1;
  localparam int MAG_W   = SB + HI_BITS;
  localparam int T_W     = 2 * SB + 1;
  localparam int R_W     = HI_BITS + mwo_pkg::HI_SHIFT + T_W - mwo_pkg::ROUND_SHIFT;
  localparam logic [T_W-1:0] RND = T_W'(1) << (mwo_pkg::ROUND_SHIFT - 1);

  logic [SUM_BITS-1:0]              mag_c;
  logic [MAG_W-1:0]                 mag_r;
  logic [2*SB-1:0]                  plo_r;
  logic [HI_BITS-1:0]               mhi_r;
  logic [HI_BITS+SB-1:0]            phi_r;
  logic [T_W-1:0]                   t_r;
  logic [R_W-1:0]                   r_c;
  logic [mwo_pkg::OUT_BITS-1:0]     rs_c, rs_r;
  logic                             neg4_r, neg5_r, neg6_r, neg7_r;

  always_comb begin
    mag_c = acc[SUM_BITS-1] ? (~acc + 1'b1) : acc;
  end

  always_ff @(posedge clk) begin
    if (ctl.abs_ld) begin
      mag_r  <= MAG_W'(mag_c);
      neg4_r <= acc[SUM_BITS-1];
    end
    if (ctl.mul_lo_ld) begin
      plo_r  <= mag_r[SB-1:0] * mm_per_count;
      mhi_r  <= mag_r[MAG_W-1:SB];
      neg5_r <= neg4_r;
    end
    if (ctl.mul_hi_ld) begin
      phi_r  <= mhi_r * mm_per_count;
      t_r    <= {1'b0, plo_r} + RND;
      neg6_r <= neg5_r;
    end
  end

  always_comb begin
    r_c = R_W'({phi_r, {mwo_pkg::HI_SHIFT{1'b0}}})
        + R_W'(t_r[T_W-1:mwo_pkg::ROUND_SHIFT]);
    if (neg6_r) begin
      rs_c = (r_c > R_W'(mwo_pkg::OUT_NEG_MAG)) ? mwo_pkg::OUT_NEG_MAG
                                                : r_c[mwo_pkg::OUT_BITS-1:0];
    end else begin
      rs_c = (r_c > R_W'(mwo_pkg::OUT_POS_MAX)) ? mwo_pkg::OUT_POS_MAX
                                                : r_c[mwo_pkg::OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sat_ld) begin
      rs_r   <= rs_c;
      neg7_r <= neg6_r;
    end
    if (ctl.out_ld) begin
      out_r <= neg7_r ? (~rs_r + 1'b1) : rs_r;
    end
  end

endmodule

### rtl/core/mecanum_wheel_odometry.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_odometry: body-frame odometry from four mecanum wheel encoders
// Angle tracking lanes, mecanum merge, saturating accumulators, mm scaling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat carries a command and four
//   encoder angles with per-wheel valid bits. Command update folds the
//   angle changes into the body sums, clear zeroes the sums, re-reference
//   makes the next update only capture angles; any other code is a no-op.
//   Output channel (out_valid / out_stall): every input beat yields exactly
//   one beat with both accumulators in millimetres, signed Q32.16.
//   Configuration: cfg_we with cfg_wdata loads mm_per_count (Q0.32); write it
//   only while no beat is in flight.
// Timing:
//   Throughput is one beat per cycle while the output is not stalled;
//   the accumulator add/saturate loop closes on its own register, and the
//   scale multiply is spread over two stages as low and high partial products.
// Reset: accumulators and stored angles clear, the first-pass flag sets,
//   the scale returns to its default, and the pipeline empties.
// Stall: a stalled output holds its beat; upstream stages keep filling
//   bubbles and in_stall rises only once all eight stages are occupied.
// ----------------------------------------------------------------------------
module mecanum_wheel_odometry #(
  parameter int ANGLE_BITS = 13,
  parameter int SUM_BITS   = 40
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mwo_pkg::CMD_BITS-1:0]        in_cmd,
  input  logic [ANGLE_BITS-1:0]               in_wheel_count_0,
  input  logic [ANGLE_BITS-1:0]               in_wheel_count_1,
  input  logic [ANGLE_BITS-1:0]               in_wheel_count_2,
  input  logic [ANGLE_BITS-1:0]               in_wheel_count_3,
  input  logic                                in_wheel_valid_0,
  input  logic                                in_wheel_valid_1,
  input  logic                                in_wheel_valid_2,
  input  logic                                in_wheel_valid_3,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mwo_pkg::OUT_BITS-1:0] out_body_x_mm,
  output logic signed [mwo_pkg::OUT_BITS-1:0] out_body_y_mm,
  // configuration
  input  logic                                cfg_we,
  input  logic [mwo_pkg::SCALE_BITS-1:0]      cfg_wdata
);

  localparam int NS = mwo_pkg::PIPE_STAGES;
  localparam int NW = mwo_pkg::NUM_WHEELS;

  logic [mwo_pkg::SCALE_BITS-1:0]     mm_per_count_r;
  logic                               first_pass_r;
  logic [mwo_pkg::CMD_BITS-1:0]       cmd_s1_r;
  logic [NS:1]                        v_r;
  logic [NS+1:1]                      rdy;
  logic [NS:1]                        ld;
  logic                               in_fire;
  logic                               is_update;

  logic [NW-1:0][ANGLE_BITS-1:0]      counts;
  logic [NW-1:0]                      wvalid;
  logic [NW-1:0][ANGLE_BITS:0]        deltas;

  logic signed [SUM_BITS-1:0]         sum_x, sum_y;
  logic [mwo_pkg::OUT_BITS-1:0]       out_x, out_y;

  mwo_pkg::acc_ctl_t                  acc_ctl;
  mwo_pkg::scale_ctl_t                scale_ctl;

  // Stage handshake: a stage takes a beat when it is empty or its beat moves on.
  always_comb begin
    rdy[NS+1] = !out_stall;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ld[1] = rdy[1] && in_valid;
    for (int k = 2; k <= NS; k++) begin
      ld[k] = rdy[k] && v_r[k-1];
    end
  end

  assign in_stall  = !rdy[1];
  assign in_fire   = ld[1];
  assign out_valid = v_r[NS];
  assign is_update = (in_cmd == mwo_pkg::CMD_UPDATE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Scale register, written only while the pipeline is empty: the user's duty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_per_count_r <= mwo_pkg::MM_PER_COUNT_RESET;
    end else if (cfg_we) begin
      mm_per_count_r <= cfg_wdata;
    end
  end

  // First-pass flag: drop on any update, raise on re-reference.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pass_r <= 1'b1;
    end else if (in_fire) begin
      case (in_cmd)
        mwo_pkg::CMD_UPDATE: first_pass_r <= 1'b0;
        mwo_pkg::CMD_REREF:  first_pass_r <= 1'b1;
        default:             first_pass_r <= first_pass_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_s1_r <= in_cmd;
    end
  end

  assign counts = {in_wheel_count_3, in_wheel_count_2, in_wheel_count_1, in_wheel_count_0};
  assign wvalid = {in_wheel_valid_3, in_wheel_valid_2, in_wheel_valid_1, in_wheel_valid_0};

  // Stage 1: one lane per wheel.
  for (genvar w = 0; w < NW; w++) begin : g_lane
    mwo_wheel_lane #(
      .ANGLE_BITS (ANGLE_BITS)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ld          (in_fire),
      .is_update   (is_update),
      .first_pass  (first_pass_r),
      .wheel_valid (wvalid[w]),
      .wheel_count (counts[w]),
      .delta_r     (deltas[w])
    );
  end

  // Stages 2 and 3: merge the lanes and accumulate.
  assign acc_ctl.merge_ld = ld[2];
  assign acc_ctl.acc_ld   = ld[3];

  mwo_body_acc #(
    .ANGLE_BITS (ANGLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl),
    .cmd_in  (cmd_s1_r),
    .deltas  (deltas),
    .sum_x_r (sum_x),
    .sum_y_r (sum_y)
  );

  // Stages 4 to 8: scale both sums to mm.
  assign scale_ctl.abs_ld    = ld[4];
  assign scale_ctl.mul_lo_ld = ld[5];
  assign scale_ctl.mul_hi_ld = ld[6];
  assign scale_ctl.sat_ld    = ld[7];
  assign scale_ctl.out_ld    = ld[8];

  mwo_scale #(
    .SUM_BITS (SUM_BITS)
  ) u_scale_x (
    .clk          (clk),
    .ctl          (scale_ctl),
    .mm_per_count (mm_per_count_r),
    .acc          (sum_x),
    .out_r        (out_x)
  );

  mwo_scale #(
    .SUM_BITS (SUM_BITS)
  ) u_scale_y (
    .clk          (clk),
    .ctl          (scale_ctl),
    .mm_per_count (mm_per_count_r),
    .acc          (sum_y),
    .out_r        (out_y)
  );

  assign out_body_x_mm = $signed(out_x);
  assign out_body_y_mm = $signed(out_y);

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with a free stage");

  a_update_clears_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == mwo_pkg::CMD_UPDATE) |=> !first_pass_r)
    else $error("first pass flag still set after update");

  a_reref_sets_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == mwo_pkg::CMD_REREF) |=> first_pass_r)
    else $error("first pass flag not set after re-reference");

endmodule

### tb/mecanum_wheel_odometry_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mecanum_wheel_odometry_test: self-checking bench for the wheel odometry block
// Drives command and encoder beats through the valid/stall handshake, tracks
// angles, body sums and mm scaling in a local predictor, and compares every
// result beat field by field. Covers directed corner cases, full-scale ramps
// on both sums, and random traffic under several scale and idling settings.
// ----------------------------------------------------------------------------
module mecanum_wheel_odometry_test;

  // Widths follow the block's defaults; the predictor clamps at the same sum width.
  localparam int ANGLE_W        = 13;
  localparam int SUM_W          = 40;
  localparam int LATENCY        = mwo_pkg::PIPE_STAGES;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BEATS    = 190;
  localparam int HALF_TURN      = 1 << (ANGLE_W - 1);
  localparam int FULL_TURN      = 1 << ANGLE_W;
  // Largest step that unwraps to the same sign from any angle.
  localparam int RAMP_STEP      = HALF_TURN - 1;
  localparam int RAMP_BEATS     = 16;
  localparam longint SUM_HI     = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_LO     = -SUM_HI - 1;

  // The package names three commands; the fourth code is a no-op.
  localparam logic [mwo_pkg::CMD_BITS-1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [mwo_pkg::CMD_BITS-1:0]  cmd;
    logic [3:0][ANGLE_W-1:0]       count;
    logic [3:0]                    wvalid;
  } wheel_beat_t;

  typedef struct packed {
    logic [mwo_pkg::OUT_BITS-1:0] x;
    logic [mwo_pkg::OUT_BITS-1:0] y;
  } body_mm_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                                 in_valid         = 1'b0;
  logic                                 in_stall;
  logic [mwo_pkg::CMD_BITS-1:0]         in_cmd           = '0;
  logic [ANGLE_W-1:0]                   in_wheel_count_0 = '0;
  logic [ANGLE_W-1:0]                   in_wheel_count_1 = '0;
  logic [ANGLE_W-1:0]                   in_wheel_count_2 = '0;
  logic [ANGLE_W-1:0]                   in_wheel_count_3 = '0;
  logic                                 in_wheel_valid_0 = 1'b0;
  logic                                 in_wheel_valid_1 = 1'b0;
  logic                                 in_wheel_valid_2 = 1'b0;
  logic                                 in_wheel_valid_3 = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall        = 1'b0;
  logic signed [mwo_pkg::OUT_BITS-1:0]  out_body_x_mm;
  logic signed [mwo_pkg::OUT_BITS-1:0]  out_body_y_mm;
  logic                                 cfg_we           = 1'b0;
  logic [mwo_pkg::SCALE_BITS-1:0]       cfg_wdata        = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mecanum_wheel_odometry #(
    .ANGLE_BITS (ANGLE_W),
    .SUM_BITS   (SUM_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_wheel_count_0 (in_wheel_count_0),
    .in_wheel_count_1 (in_wheel_count_1),
    .in_wheel_count_2 (in_wheel_count_2),
    .in_wheel_count_3 (in_wheel_count_3),
    .in_wheel_valid_0 (in_wheel_valid_0),
    .in_wheel_valid_1 (in_wheel_valid_1),
    .in_wheel_valid_2 (in_wheel_valid_2),
    .in_wheel_valid_3 (in_wheel_valid_3),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_body_x_mm    (out_body_x_mm),
    .out_body_y_mm    (out_body_y_mm),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Predictor state: stored angles, capture flag, body sums in quarter counts
  // and the scale register. Reset values match the block's reset.
  // --------------------------------------------------------------------------
  logic [ANGLE_W-1:0]             track_angle [4] = '{default: '0};
  logic                           capture_next    = 1'b1;
  longint                         sum_x_q         = 0;
  longint                         sum_y_q         = 0;
  logic [mwo_pkg::SCALE_BITS-1:0] mm_per_count    = mwo_pkg::MM_PER_COUNT_RESET;

  body_mm_t body_expect_q [$];

  // traffic shaping, in percent
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // bookkeeping for the summary
  int fail_count      = 0;
  int results_checked = 0;
  int scale_writes    = 0;
  int sum_clamps      = 0;
  int cmd_seen [4]    = '{default: 0};

  // --------------------------------------------------------------------------
  // Predictor helpers
  // --------------------------------------------------------------------------

  // Fold the raw angle change into -HALF_TURN..+HALF_TURN; exact halves stay.
  function automatic int unwrap_delta(input logic [ANGLE_W-1:0] now_angle,
                                      input logic [ANGLE_W-1:0] old_angle);
    int d;
    d = int'(now_angle) - int'(old_angle);
    if (d > HALF_TURN) d -= FULL_TURN;
    if (d < -HALF_TURN) d += FULL_TURN;
    return d;
  endfunction

  // Quarter counts times the Q0.32 scale, down to mm Q32.16: round half away
  // from zero on the magnitude, then clamp to the 48-bit signed range.
  function automatic logic [mwo_pkg::OUT_BITS-1:0] to_mm_q16(
      input longint acc, input logic [mwo_pkg::SCALE_BITS-1:0] scale);
    logic [79:0] mag;
    logic [79:0] prod;
    logic        neg;
    neg  = acc < 0;
    mag  = neg ? -acc : acc;
    prod = mag * {48'd0, scale};
    prod = (prod + (80'd1 << (mwo_pkg::ROUND_SHIFT - 1))) >> mwo_pkg::ROUND_SHIFT;
    if (neg) begin
      if (prod > {32'd0, mwo_pkg::OUT_NEG_MAG}) prod = {32'd0, mwo_pkg::OUT_NEG_MAG};
      return ~prod[mwo_pkg::OUT_BITS-1:0] + 1'b1;
    end
    if (prod > {32'd0, mwo_pkg::OUT_POS_MAX}) prod = {32'd0, mwo_pkg::OUT_POS_MAX};
    return prod[mwo_pkg::OUT_BITS-1:0];
  endfunction

  function automatic longint clamp_body_sum(input longint raw);
    if (raw > SUM_HI) return SUM_HI;
    if (raw < SUM_LO) return SUM_LO;
    return raw;
  endfunction

  // Advance the predictor by one accepted beat and queue the result it owes.
  task automatic predict_body(input wheel_beat_t b);
    int       d [4];
    int       w;
    longint   raw_x;
    longint   raw_y;
    body_mm_t r;
    cmd_seen[b.cmd]++;
    case (b.cmd)
      mwo_pkg::CMD_UPDATE: begin
        for (w = 0; w < 4; w++) begin
          d[w] = 0;
          if (b.wvalid[w]) begin
            if (!capture_next) d[w] = unwrap_delta(b.count[w], track_angle[w]);
            track_angle[w] = b.count[w];
          end
        end
        capture_next = 1'b0;
        raw_x = sum_x_q + d[0] + d[1] - d[2] - d[3];
        raw_y = sum_y_q - d[0] + d[1] - d[2] + d[3];
        if (raw_x != clamp_body_sum(raw_x)) sum_clamps++;
        if (raw_y != clamp_body_sum(raw_y)) sum_clamps++;
        sum_x_q = clamp_body_sum(raw_x);
        sum_y_q = clamp_body_sum(raw_y);
      end
      mwo_pkg::CMD_CLEAR: begin
        sum_x_q = 0;
        sum_y_q = 0;
      end
      mwo_pkg::CMD_REREF: capture_next = 1'b1;
      default: ;
    endcase
    r.x = to_mm_q16(sum_x_q, mm_per_count);
    r.y = to_mm_q16(sum_y_q, mm_per_count);
    body_expect_q.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic wheel_beat_t make_beat(input logic [mwo_pkg::CMD_BITS-1:0] cmd,
                                            input logic [ANGLE_W-1:0] c0,
                                            input logic [ANGLE_W-1:0] c1,
                                            input logic [ANGLE_W-1:0] c2,
                                            input logic [ANGLE_W-1:0] c3,
                                            input logic [3:0] wvalid);
    wheel_beat_t b;
    b.cmd      = cmd;
    b.count[0] = c0;
    b.count[1] = c1;
    b.count[2] = c2;
    b.count[3] = c3;
    b.wvalid   = wvalid;
    return b;
  endfunction

  // Pick the next angle of a wheel relative to where the predictor has it:
  // small motion most often, plus raw angles, near-half and exact-half jumps.
  function automatic logic [ANGLE_W-1:0] next_angle(input int w);
    int k;
    int d;
    k = $urandom_range(9);
    case (k)
      0, 1, 2, 3: d = int'($urandom_range(200)) - 100;
      4, 5:       return ANGLE_W'($urandom);
      6:          d = HALF_TURN + int'($urandom_range(4)) - 2;
      7:          d = HALF_TURN;
      8:          d = int'($urandom_range(2 * HALF_TURN)) - HALF_TURN;
      default:    d = 0;
    endcase
    if ((k == 6 || k == 7) && $urandom_range(1)) d = -d;
    return ANGLE_W'(int'(track_angle[w]) + d);
  endfunction

  function automatic wheel_beat_t random_beat();
    wheel_beat_t b;
    int          pick;
    int          w;
    pick = $urandom_range(99);
    if (pick < 85)      b.cmd = mwo_pkg::CMD_UPDATE;
    else if (pick < 90) b.cmd = mwo_pkg::CMD_CLEAR;
    else if (pick < 95) b.cmd = mwo_pkg::CMD_REREF;
    else                b.cmd = CMD_NOP;
    for (w = 0; w < 4; w++) begin
      b.count[w]  = (b.cmd == mwo_pkg::CMD_UPDATE) ? next_angle(w) : ANGLE_W'($urandom);
      b.wvalid[w] = $urandom_range(9) != 0;
    end
    return b;
  endfunction

  task automatic set_traffic(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Drop valid and hold until every queued result has been accepted.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (body_expect_q.size() != 0);
  endtask

  // Load the scale register once the pipeline is empty.
  task automatic set_scale(input logic [mwo_pkg::SCALE_BITS-1:0] value);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    mm_per_count  = value;
    scale_writes++;
  endtask

  // Send one beat: optional idle gap, then hold valid and payload until the
  // block takes it, then advance the predictor.
  task automatic send_beat(input wheel_beat_t b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_cmd           <= b.cmd;
    in_wheel_count_0 <= b.count[0];
    in_wheel_count_1 <= b.count[1];
    in_wheel_count_2 <= b.count[2];
    in_wheel_count_3 <= b.count[3];
    in_wheel_valid_0 <= b.wvalid[0];
    in_wheel_valid_1 <= b.wvalid[1];
    in_wheel_valid_2 <= b.wvalid[2];
    in_wheel_valid_3 <= b.wvalid[3];
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_body(b);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases at the reset scale: capture on first pass, wrap through
  // zero, exact half turns both ways, missing wheels, clear, re-reference,
  // the no-op code, and all-ones / all-zeros angles.
  task automatic test_directed();
    set_traffic(0, 0);
    // first pass with wheel two absent: capture only
    send_beat(make_beat(mwo_pkg::CMD_UPDATE, 13'h0000, 13'h1FFF, 13'h1555, 13'h0AAA, 4'b1011));
    // wrap by one each way; exact +half on wheels two and three
    send_beat(make_beat(mwo_pkg::CMD_UPDATE, 13'h1FFF, 13'h0000, 13'h1000, 13'h1AAA, 4'b1111));
    // exact -half on wheel two; one past half on wheels one and three
    send_beat(make_beat(mwo_pkg::CMD_UPDATE, 13'h0000, 13'h1001, 13'h0000, 13'h0AA9, 4'b1111));
    // no wheel present: sums and stored angles hold
    send_beat(make_beat(mwo_pkg::CMD_UPDATE, 13'h1234, 13'h0ABC, 13'h1F0F, 13'h00F0, 4'b0000));
    send_beat(make_beat(mwo_pkg::CMD_UPDATE, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 4'b0101));
    send_beat(make_beat(CMD_NOP, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 4'b1111));
    send_beat(make_beat(mwo_pkg::CMD_CLEAR, 13'h0000, 13'h1FFF, 13'h0000, 13'h1FFF, 4'b1111));
    send_beat(make_beat(mwo_pkg::CMD_UPDATE, 13'h0800, 13'h0400, 13'h0200, 13'h0100, 4'b1111));
    // re-reference: next update captures, the one after moves the sums
    send_beat(make_beat(mwo_pkg::CMD_REREF, 13'h1555, 13'h0AAA, 13'h1555, 13'h0AAA, 4'b1010));
    send_beat(make_beat(mwo_pkg::CMD_UPDATE, 13'h1000, 13'h1000, 13'h1000, 13'h1000, 4'b1111));
    send_beat(make_beat(mwo_pkg::CMD_UPDATE, 13'h1100, 13'h0F00, 13'h1080, 13'h1000, 4'b1111));
    // stacked re-references and a clear while a capture is pending
    send_beat(make_beat(mwo_pkg::CMD_REREF, 13'h0000, 13'h0000, 13'h0000, 13'h0000, 4'b0000));
    send_beat(make_beat(mwo_pkg::CMD_REREF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 4'b1111));
    send_beat(make_beat(mwo_pkg::CMD_CLEAR, 13'h0F0F, 13'h10F0, 13'h0F0F, 13'h10F0, 4'b0110));
    // capture with nothing present still ends the first pass
    send_beat(make_beat(mwo_pkg::CMD_UPDATE, 13'h0555, 13'h0555, 13'h0555, 13'h0555, 4'b0000));
    send_beat(make_beat(mwo_pkg::CMD_UPDATE, 13'h0000, 13'h0000, 13'h0000, 13'h0000, 4'b1111));
    send_beat(make_beat(CMD_NOP, 13'h0000, 13'h0000, 13'h0000, 13'h0000, 4'b0000));
    send_beat(make_beat(mwo_pkg::CMD_UPDATE, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 4'b1111));
  endtask

  // Ramp x up in the largest same-sign steps, then y down, at the full-scale
  // setting so the mm outputs carry wide products on both signs.
  task automatic test_full_scale_ramp();
    wheel_beat_t b;
    int          n;
    set_scale(32'hFFFF_FFFF);
    set_traffic(9, 9);
    send_beat(make_beat(mwo_pkg::CMD_CLEAR, 13'h0000, 13'h0000, 13'h0000, 13'h0000, 4'b0000));
    b.cmd    = mwo_pkg::CMD_UPDATE;
    b.wvalid = 4'b1111;
    for (n = 0; n < RAMP_BEATS; n++) begin
      b.count[0] = ANGLE_W'(int'(track_angle[0]) + RAMP_STEP);
      b.count[1] = ANGLE_W'(int'(track_angle[1]) + RAMP_STEP);
      b.count[2] = ANGLE_W'(int'(track_angle[2]) - RAMP_STEP);
      b.count[3] = ANGLE_W'(int'(track_angle[3]) - RAMP_STEP);
      send_beat(b);
    end
    // this pattern leaves x alone and drives y negative
    for (n = 0; n < RAMP_BEATS; n++) begin
      b.count[0] = ANGLE_W'(int'(track_angle[0]) + RAMP_STEP);
      b.count[1] = ANGLE_W'(int'(track_angle[1]) - RAMP_STEP);
      b.count[2] = ANGLE_W'(int'(track_angle[2]) + RAMP_STEP);
      b.count[3] = ANGLE_W'(int'(track_angle[3]) - RAMP_STEP);
      send_beat(b);
    end
    send_beat(make_beat(mwo_pkg::CMD_CLEAR, 13'h0000, 13'h0000, 13'h0000, 13'h0000, 4'b1111));
  endtask

  // Random motion in four traffic phases, each with its own scale setting.
  task automatic test_random_traffic();
    int p;
    int n;
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          set_scale(mwo_pkg::MM_PER_COUNT_RESET);
          set_traffic(0, 0);
        end
        1: begin
          set_scale(32'd0);
          set_traffic(87, 0);
        end
        2: begin
          set_scale($urandom);
          set_traffic(0, 87);
        end
        default: begin
          set_scale(32'h8000_0000);
          set_traffic(9, 9);
        end
      endcase
      for (n = 0; n < PHASE_BEATS; n++) begin
        // hold the sender mid-phase until the pipeline has emptied
        if (n == PHASE_BEATS / 2) wait_results_drained();
        send_beat(random_beat());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stall, per the current phase.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each accepted result beat with the oldest queued prediction.
  always @(posedge clk) begin
    body_mm_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (body_expect_q.size() == 0) begin
        $error("result beat with nothing expected: body_x_mm %0d body_y_mm %0d",
               out_body_x_mm, out_body_y_mm);
        fail_count++;
      end else begin
        want = body_expect_q.pop_front();
        results_checked++;
        if (out_body_x_mm !== want.x) begin
          $error("body_x_mm: expected %0d, actual %0d", $signed(want.x), out_body_x_mm);
          fail_count++;
        end
        if (out_body_y_mm !== want.y) begin
          $error("body_y_mm: expected %0d, actual %0d", $signed(want.y), out_body_y_mm);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("mecanum_wheel_odometry_test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_scale_ramp();
    test_random_traffic();
    // let the tail drain, then watch for stray beats
    wait_results_drained();
    repeat (4 * LATENCY) @(posedge clk);
    $display("ran %0d updates, %0d clears, %0d re-references, %0d no-ops; %0d results checked",
             cmd_seen[mwo_pkg::CMD_UPDATE], cmd_seen[mwo_pkg::CMD_CLEAR],
             cmd_seen[mwo_pkg::CMD_REREF], cmd_seen[CMD_NOP], results_checked);
    $display("%0d scale settings loaded, body sums clamped %0d times", scale_writes, sum_clamps);
    if (fail_count == 0) begin
      $display("mecanum_wheel_odometry_test passed");
    end else begin
      $display("mecanum_wheel_odometry_test failed");
    end
    $finish;
  end

endmodule
